// ===== src/hcs_pkg.sv =====
// Shared constants, types and codes for the histogram contrast stretch block.
package hcs_pkg;

    localparam int PIX_W        = 8;
    localparam int FRAME_PIXELS = 4096;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);
    localparam int CNT_W        = $clog2(FRAME_PIXELS + 1);
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 16;
    localparam int STEP_W       = $clog2(PIX_W);

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_MIN = '0;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_FRAME = 2'd1,
        STATUS_FLAT     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

endpackage

// ===== src/histogram_contrast_stretch.sv =====
// Top level: frame store, min/max tracking and stretched-pixel readout.
//
//  port group  dir  tdata (low bit up)                tuser   tlast
//  s_*         in   pixel_in[7:0]                     opcode  frame_end
//  m_*         out  pixel_out[7:0], status[9:8]       -       last_pixel
//
// A load leaves the block idle and ready for the next word. A read that stretches
// a pixel passes the frame memory read, the divider load, eight divider steps,
// then the result and output registers; no new word is taken until it reaches
// the output register. Flat reads skip the divider; no-frame reads skip both.
// Reset is synchronous; the frame memory has no reset and needs no clear pass.
// A stalled output word holds while loads keep being accepted; a finished read
// waits for the output register and holds off the input until then.
module histogram_contrast_stretch (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hcs_pkg::IN_DATA_W-1:0]  s_tdata,   // pixel_in[7:0]
    input  logic                           s_tlast,
    input  logic                           s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hcs_pkg::OUT_DATA_W-1:0] m_tdata,   // pixel_out[7:0], status[9:8]
    output logic                           m_tlast
);

    import hcs_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rdpos_reg, rdpos_next;
    logic [PIX_W-1:0]      min_reg, min_next;
    logic [PIX_W-1:0]      max_reg, max_next;
    logic                  closed_reg, closed_next;
    logic [PIX_W-1:0]      res_pixel_reg, res_pixel_next;
    logic                  res_last_reg, res_last_next;
    status_t               res_status_reg, res_status_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;

    logic                  accept;
    op_t                   op;
    logic [PIX_W-1:0]      pix;
    logic [CNT_W-1:0]      base_count;
    logic [PIX_W-1:0]      base_min;
    logic [PIX_W-1:0]      base_max;
    logic [CNT_W-1:0]      pos;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [PIX_W-1:0]      ram_rdata;
    logic [PIX_W-1:0]      span;
    logic [PIX_W-1:0]      off;
    logic [2*PIX_W-1:0]    product;
    logic                  div_start;
    logic                  div_done;
    logic [PIX_W-1:0]      div_q;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign pix      = s_tdata[PIX_W-1:0];

    assign base_count = closed_reg ? '0 : count_reg;
    assign base_min   = closed_reg ? PIX_MAX : min_reg;
    assign base_max   = closed_reg ? PIX_MIN : max_reg;
    assign pos        = (rdpos_reg >= count_reg) ? '0 : rdpos_reg;
    assign ram_waddr  = base_count[ADDR_W-1:0];
    assign ram_raddr  = pos[ADDR_W-1:0];

    assign span    = max_reg - min_reg;
    assign off     = (ram_rdata > min_reg) ? ram_rdata - min_reg : '0;
    assign product = (2*PIX_W)'(off) * (2*PIX_W)'(PIX_MAX);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rdpos_next      = rdpos_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        closed_next     = closed_reg;
        res_pixel_next  = res_pixel_reg;
        res_last_next   = res_last_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && op == OP_LOAD) begin
                    closed_next = s_tlast;
                    count_next  = base_count;
                    min_next    = base_min;
                    max_next    = base_max;
                    if (closed_reg) begin
                        rdpos_next = '0;
                    end
                    if (base_count < CNT_W'(FRAME_PIXELS)) begin
                        ram_we     = 1'b1;
                        count_next = base_count + CNT_W'(1);
                        if (pix < base_min) begin
                            min_next = pix;
                        end
                        if (pix > base_max) begin
                            max_next = pix;
                        end
                    end
                end else if (accept) begin
                    if (!closed_reg || count_reg == '0) begin
                        res_pixel_next  = '0;
                        res_last_next   = 1'b0;
                        res_status_next = STATUS_NO_FRAME;
                        state_next      = ST_HOLD;
                    end else begin
                        ram_re        = 1'b1;
                        res_last_next = (pos + CNT_W'(1) == count_reg);
                        rdpos_next    = (pos + CNT_W'(1) == count_reg) ? '0
                                                                       : pos + CNT_W'(1);
                        state_next    = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                if (max_reg <= min_reg) begin
                    res_pixel_next  = '0;
                    res_status_next = STATUS_FLAT;
                    state_next      = ST_HOLD;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    res_pixel_next  = div_q;
                    res_status_next = STATUS_OK;
                    state_next      = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_DATA_W'({res_status_reg, res_pixel_reg});
                    m_last_next  = res_last_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rdpos_reg   <= '0;
            min_reg     <= PIX_MAX;
            max_reg     <= PIX_MIN;
            closed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rdpos_reg   <= rdpos_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            closed_reg  <= closed_next;
            m_valid_reg <= m_valid_next;
        end
        res_pixel_reg  <= res_pixel_next;
        res_last_reg   <= res_last_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
    end

    hcs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_PIXELS)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pix),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hcs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (span),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== src/hcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/hcs_div.sv =====
// Bit-serial restoring divider for a quotient known to fit in one pixel.
module hcs_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [2*hcs_pkg::PIX_W-1:0] dividend,
    input  logic [hcs_pkg::PIX_W-1:0] divisor,
    output logic                      done,
    output logic [hcs_pkg::PIX_W-1:0] quotient
);

    import hcs_pkg::*;

    logic [PIX_W-1:0]  rem_reg, rem_next;
    logic [PIX_W-1:0]  dvd_reg, dvd_next;
    logic [PIX_W-1:0]  dsr_reg, dsr_next;
    logic [PIX_W-1:0]  q_reg, q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [PIX_W:0]    trial;
    logic [PIX_W:0]    diff;
    logic              ge;

    always_comb begin
        trial     = {rem_reg, dvd_reg[PIX_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = (trial >= {1'b0, dsr_reg});
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend[2*PIX_W-1:PIX_W];
            dvd_next  = dividend[PIX_W-1:0];
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
            dvd_next  = {dvd_reg[PIX_W-2:0], 1'b0};
            q_next    = {q_reg[PIX_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(PIX_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/hcs_checker.sv =====
// Port-level checks for the histogram contrast stretch block, bound to the top.
module hcs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hcs_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    import hcs_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:8] == STATUS_OK || m_tdata[9:8] == STATUS_NO_FRAME
                     || m_tdata[9:8] == STATUS_FLAT)
        else $error("undefined status code");

    a_zero_unless_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:8] != STATUS_OK |-> m_tdata[PIX_W-1:0] == '0)
        else $error("nonzero pixel with non-ok status");

    a_no_frame_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:8] == STATUS_NO_FRAME |-> !m_tlast)
        else $error("last flag on a no-frame word");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind histogram_contrast_stretch hcs_checker u_hcs_checker (.*);
